// ----- rtl/core/aid_pkg.sv -----
// ----------------------------------------------------------------------------
// aid_pkg
// Opcode class numbers and the decode result type shared by the A32
// instruction decoder, its classifier and its checker.
// ----------------------------------------------------------------------------
package aid_pkg;

   typedef logic [6:0] opcode_type;

   // Result of one decode: class number and condition outcome
   typedef struct packed {
      opcode_type opcode_class;
      logic       condition_passed;
   } decode_type;

   // Special classes
   localparam opcode_type OP_INVALID  = 7'd0;
   localparam opcode_type OP_UNSUP    = 7'd1;
   localparam opcode_type OP_NOTEXEC  = 7'd2;
   localparam opcode_type OP_MOVW     = 7'd3;
   localparam opcode_type OP_MOVT     = 7'd4;

   // Single load/store
   localparam opcode_type OP_STR_I    = 7'd5;
   localparam opcode_type OP_STRT     = 7'd6;
   localparam opcode_type OP_LDR_I    = 7'd7;
   localparam opcode_type OP_LDR_L    = 7'd8;
   localparam opcode_type OP_LDRT     = 7'd9;
   localparam opcode_type OP_STRB_I   = 7'd10;
   localparam opcode_type OP_STRBT    = 7'd11;
   localparam opcode_type OP_LDRB_I   = 7'd12;
   localparam opcode_type OP_LDRB_L   = 7'd13;
   localparam opcode_type OP_LDRBT    = 7'd14;
   localparam opcode_type OP_STR_R    = 7'd15;
   localparam opcode_type OP_LDR_R    = 7'd16;
   localparam opcode_type OP_STRB_R   = 7'd17;
   localparam opcode_type OP_LDRB_R   = 7'd18;

   // Block transfer and branch
   localparam opcode_type OP_STMDA    = 7'd19;
   localparam opcode_type OP_LDMDA    = 7'd20;
   localparam opcode_type OP_STMIA    = 7'd21;
   localparam opcode_type OP_LDMIA    = 7'd22;
   localparam opcode_type OP_POPM     = 7'd23;
   localparam opcode_type OP_STMDB    = 7'd24;
   localparam opcode_type OP_PUSHM    = 7'd25;
   localparam opcode_type OP_LDMDB    = 7'd26;
   localparam opcode_type OP_STMIB    = 7'd27;
   localparam opcode_type OP_LDMIB    = 7'd28;
   localparam opcode_type OP_STMU     = 7'd29;
   localparam opcode_type OP_LDMU     = 7'd30;
   localparam opcode_type OP_BR       = 7'd31;
   localparam opcode_type OP_BLI      = 7'd32;

   // Data processing, register operand (AND_R..RSC_R consecutive)
   localparam opcode_type OP_AND_R    = 7'd33;
   localparam opcode_type OP_TST_R    = 7'd41;
   localparam opcode_type OP_ORR_R    = 7'd45;
   localparam opcode_type OP_MOV_R    = 7'd46;
   localparam opcode_type OP_LSL_I    = 7'd47;
   localparam opcode_type OP_LSR_I    = 7'd48;
   localparam opcode_type OP_ASR_I    = 7'd49;
   localparam opcode_type OP_RRX_R    = 7'd50;
   localparam opcode_type OP_ROR_I    = 7'd51;
   localparam opcode_type OP_BIC_R    = 7'd52;
   localparam opcode_type OP_MVN_R    = 7'd53;

   // Data processing, register-shifted register (AND_S..RSC_S consecutive)
   localparam opcode_type OP_AND_S    = 7'd54;
   localparam opcode_type OP_TST_S    = 7'd62;
   localparam opcode_type OP_ORR_S    = 7'd66;
   localparam opcode_type OP_LSL_S    = 7'd67;
   localparam opcode_type OP_BIC_S    = 7'd71;
   localparam opcode_type OP_MVN_S    = 7'd72;

   // Miscellaneous
   localparam opcode_type OP_BXR      = 7'd73;
   localparam opcode_type OP_CLZR     = 7'd74;
   localparam opcode_type OP_BLXR     = 7'd75;
   localparam opcode_type OP_QADDR    = 7'd76;

   // Extra load/store
   localparam opcode_type OP_STRH_R   = 7'd80;
   localparam opcode_type OP_LDRH_R   = 7'd81;
   localparam opcode_type OP_STRH_I   = 7'd82;
   localparam opcode_type OP_LDRH_I   = 7'd83;
   localparam opcode_type OP_LDRH_L   = 7'd84;
   localparam opcode_type OP_LDRD_R   = 7'd85;
   localparam opcode_type OP_LDRSB_R  = 7'd86;
   localparam opcode_type OP_LDRD_I   = 7'd87;
   localparam opcode_type OP_LDRD_L   = 7'd88;
   localparam opcode_type OP_LDRSB_I  = 7'd89;
   localparam opcode_type OP_LDRSB_L  = 7'd90;
   localparam opcode_type OP_STRD_R   = 7'd91;
   localparam opcode_type OP_LDRSH_R  = 7'd92;
   localparam opcode_type OP_STRD_I   = 7'd93;
   localparam opcode_type OP_LDRSH_I  = 7'd94;
   localparam opcode_type OP_LDRSH_L  = 7'd95;
   localparam opcode_type OP_STRHT    = 7'd96;
   localparam opcode_type OP_LDRHT    = 7'd97;
   localparam opcode_type OP_LDRSBT   = 7'd98;
   localparam opcode_type OP_LDRSHT   = 7'd99;

   // Data processing, immediate operand
   localparam opcode_type OP_AND_I    = 7'd100;
   localparam opcode_type OP_ADR_I    = 7'd103;
   localparam opcode_type OP_TST_I    = 7'd109;
   localparam opcode_type OP_ORR_I    = 7'd113;
   localparam opcode_type OP_BIC_I    = 7'd114;
   localparam opcode_type OP_MVN_I    = 7'd115;

   // Highest class number in use
   localparam opcode_type OP_LAST     = OP_MVN_I;

   // Condition code and register numbers of interest
   localparam logic [3:0] COND_NEVER  = 4'b1111;
   localparam logic [3:0] RN_PC       = 4'b1111;
   localparam logic [3:0] RN_SP       = 4'b1101;

endpackage

// ----- rtl/core/aid_classify.sv -----
// ----------------------------------------------------------------------------
// aid_classify
// Combinational A32 classifier: condition check and table decode of one
// instruction word into its opcode class.
// ----------------------------------------------------------------------------
module aid_classify (
   input  logic [31:0]         word,
   input  logic [3:0]          nzcv,
   output aid_pkg::decode_type result
);

   // Standard ARM condition evaluation
   function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
      logic r;
      case (c[3:1])
         3'd0:    r = f[2];
         3'd1:    r = f[1];
         3'd2:    r = f[3];
         3'd3:    r = f[0];
         3'd4:    r = f[1] & ~f[2];
         3'd5:    r = (f[3] == f[0]);
         3'd6:    r = (f[3] == f[0]) & ~f[2];
         default: r = 1'b1;
      endcase
      if (c[0] && (c != aid_pkg::COND_NEVER)) begin
         r = ~r;
      end
      return r;
   endfunction

   // Compare group 10xx1: S bit must be set
   function automatic aid_pkg::opcode_type cmp_group(input logic [4:0] op,
                                                     input aid_pkg::opcode_type base);
      if (!op[0]) begin
         return aid_pkg::OP_INVALID;
      end
      return base + aid_pkg::opcode_type'(op[2:1]);
   endfunction

   // Data processing, register operand
   function automatic aid_pkg::opcode_type dp_reg(input logic [31:0] w);
      logic [3:0] g;
      logic [1:0] sh;
      logic       imm_zero;
      aid_pkg::opcode_type k;
      g        = w[24:21];
      sh       = w[6:5];
      imm_zero = (w[11:7] == 5'd0);
      if (!g[3]) begin
         k = aid_pkg::OP_AND_R + aid_pkg::opcode_type'(g[2:0]);
      end else begin
         case (g[2:0])
            3'd4:    k = aid_pkg::OP_ORR_R;
            3'd5: begin
               case (sh)
                  2'd0:    k = imm_zero ? aid_pkg::OP_MOV_R : aid_pkg::OP_LSL_I;
                  2'd1:    k = aid_pkg::OP_LSR_I;
                  2'd2:    k = aid_pkg::OP_ASR_I;
                  default: k = imm_zero ? aid_pkg::OP_RRX_R : aid_pkg::OP_ROR_I;
               endcase
            end
            3'd6:    k = aid_pkg::OP_BIC_R;
            3'd7:    k = aid_pkg::OP_MVN_R;
            default: k = cmp_group(w[24:20], aid_pkg::OP_TST_R);
         endcase
      end
      return k;
   endfunction

   // Data processing, register-shifted register operand
   function automatic aid_pkg::opcode_type dp_rsreg(input logic [31:0] w);
      logic [3:0] g;
      aid_pkg::opcode_type k;
      g = w[24:21];
      if (!g[3]) begin
         k = aid_pkg::OP_AND_S + aid_pkg::opcode_type'(g[2:0]);
      end else begin
         case (g[2:0])
            3'd4:    k = aid_pkg::OP_ORR_S;
            3'd5:    k = aid_pkg::OP_LSL_S + aid_pkg::opcode_type'(w[6:5]);
            3'd6:    k = aid_pkg::OP_BIC_S;
            3'd7:    k = aid_pkg::OP_MVN_S;
            default: k = cmp_group(w[24:20], aid_pkg::OP_TST_S);
         endcase
      end
      return k;
   endfunction

   // Data processing, immediate operand (ADR sits between SUB and RSB)
   function automatic aid_pkg::opcode_type dp_imm(input logic [31:0] w);
      logic [3:0] g;
      aid_pkg::opcode_type k;
      g = w[24:21];
      if (((g == 4'd2) || (g == 4'd4)) && (w[19:16] == aid_pkg::RN_PC)) begin
         k = aid_pkg::OP_ADR_I;
      end else if (!g[3]) begin
         k = (g[2:0] < 3'd3) ? aid_pkg::OP_AND_I + aid_pkg::opcode_type'(g[2:0])
                             : aid_pkg::OP_AND_I + 7'd1 + aid_pkg::opcode_type'(g[2:0]);
      end else begin
         case (g[2:0])
            3'd4:    k = aid_pkg::OP_ORR_I;
            3'd5:    k = aid_pkg::OP_MOVW;
            3'd6:    k = aid_pkg::OP_BIC_I;
            3'd7:    k = aid_pkg::OP_MVN_I;
            default: k = cmp_group(w[24:20], aid_pkg::OP_TST_I);
         endcase
      end
      return k;
   endfunction

   // Miscellaneous group
   function automatic aid_pkg::opcode_type misc(input logic [31:0] w);
      logic [1:0] op;
      logic [2:0] op2;
      aid_pkg::opcode_type k;
      op  = w[22:21];
      op2 = w[6:4];
      if (op2 == 3'd1) begin
         case (op)
            2'd1:    k = aid_pkg::OP_BXR;
            2'd3:    k = aid_pkg::OP_CLZR;
            default: k = aid_pkg::OP_INVALID;
         endcase
      end else if ((op2 == 3'd3) && (op == 2'd1)) begin
         k = aid_pkg::OP_BLXR;
      end else if (op2 == 3'd5) begin
         k = aid_pkg::OP_QADDR + aid_pkg::opcode_type'(op);
      end else begin
         k = aid_pkg::OP_UNSUP;
      end
      return k;
   endfunction

   // Extra load/store
   function automatic aid_pkg::opcode_type exls(input logic [31:0] w);
      logic imm, ld, lit;
      aid_pkg::opcode_type k;
      imm = w[22];
      ld  = w[20];
      lit = (w[19:16] == aid_pkg::RN_PC);
      case (w[6:5])
         2'd1: begin
            if (!imm)    k = ld ? aid_pkg::OP_LDRH_R : aid_pkg::OP_STRH_R;
            else if (ld) k = lit ? aid_pkg::OP_LDRH_L : aid_pkg::OP_LDRH_I;
            else         k = aid_pkg::OP_STRH_I;
         end
         2'd2: begin
            if (!imm)    k = ld ? aid_pkg::OP_LDRSB_R : aid_pkg::OP_LDRD_R;
            else if (ld) k = lit ? aid_pkg::OP_LDRSB_L : aid_pkg::OP_LDRSB_I;
            else         k = lit ? aid_pkg::OP_LDRD_L : aid_pkg::OP_LDRD_I;
         end
         2'd3: begin
            if (!imm)    k = ld ? aid_pkg::OP_LDRSH_R : aid_pkg::OP_STRD_R;
            else if (ld) k = lit ? aid_pkg::OP_LDRSH_L : aid_pkg::OP_LDRSH_I;
            else         k = aid_pkg::OP_STRD_I;
         end
         default: k = aid_pkg::OP_INVALID;
      endcase
      return k;
   endfunction

   // Extra load/store, unprivileged forms
   function automatic aid_pkg::opcode_type exls_user(input logic [31:0] w);
      aid_pkg::opcode_type k;
      case (w[6:5])
         2'd1:    k = w[20] ? aid_pkg::OP_LDRHT : aid_pkg::OP_STRHT;
         2'd2:    k = w[20] ? aid_pkg::OP_LDRSBT : aid_pkg::OP_INVALID;
         2'd3:    k = w[20] ? aid_pkg::OP_LDRSHT : aid_pkg::OP_INVALID;
         default: k = aid_pkg::OP_INVALID;
      endcase
      return k;
   endfunction

   // Data-processing and miscellaneous space (bits 27:26 = 00)
   function automatic aid_pkg::opcode_type data_space(input logic [31:0] w);
      logic [4:0] op1;
      logic [3:0] op2;
      logic       grp;
      aid_pkg::opcode_type k;
      op1 = w[24:20];
      op2 = w[7:4];
      grp = (op1[4:3] == 2'b10) && !op1[0];
      k   = aid_pkg::OP_INVALID;
      if (w[25]) begin
         if (!grp)                 k = dp_imm(w);
         else if (op1 == 5'h10)    k = aid_pkg::OP_MOVW;
         else if (op1 == 5'h14)    k = aid_pkg::OP_MOVT;
         else                      k = aid_pkg::OP_UNSUP;
      end else if (!grp && !op2[0]) begin
         k = dp_reg(w);
      end else if (!grp && !op2[3]) begin
         k = dp_rsreg(w);
      end else if (grp && !op2[3]) begin
         k = misc(w);
      end else if (grp && !op2[0]) begin
         k = aid_pkg::OP_UNSUP;
      end else if (op2 == 4'd9) begin
         // multiply or synchronisation
         k = aid_pkg::OP_UNSUP;
      end else if ((op2 == 4'd11) || (op2[3:2] == 2'b11 && op2[0])) begin
         k = (!op1[4] && op1[1]) ? exls_user(w) : exls(w);
      end
      return k;
   endfunction

   // Single load/store space
   function automatic aid_pkg::opcode_type ls_space(input logic [31:0] w);
      logic byt, ld, lit;
      aid_pkg::opcode_type k;
      byt = w[22];
      ld  = w[20];
      lit = (w[19:16] == aid_pkg::RN_PC);
      if (!w[24] && w[21]) begin
         if (byt) k = ld ? aid_pkg::OP_LDRBT : aid_pkg::OP_STRBT;
         else     k = ld ? aid_pkg::OP_LDRT : aid_pkg::OP_STRT;
      end else if (w[25]) begin
         if (byt) k = ld ? aid_pkg::OP_LDRB_R : aid_pkg::OP_STRB_R;
         else     k = ld ? aid_pkg::OP_LDR_R : aid_pkg::OP_STR_R;
      end else if (byt) begin
         k = ld ? (lit ? aid_pkg::OP_LDRB_L : aid_pkg::OP_LDRB_I) : aid_pkg::OP_STRB_I;
      end else begin
         k = ld ? (lit ? aid_pkg::OP_LDR_L : aid_pkg::OP_LDR_I) : aid_pkg::OP_STR_I;
      end
      return k;
   endfunction

   // Block transfer and branch space
   function automatic aid_pkg::opcode_type br_space(input logic [31:0] w);
      logic [5:0] op;
      logic       ld, is_sp;
      aid_pkg::opcode_type k;
      op    = w[25:20];
      ld    = op[0];
      is_sp = (w[19:16] == aid_pkg::RN_SP);
      if (op[5]) begin
         k = op[4] ? aid_pkg::OP_BLI : aid_pkg::OP_BR;
      end else if (op[2]) begin
         // user-register form; load with PC in list is exception return
         if (!ld)        k = aid_pkg::OP_STMU;
         else if (!w[15]) k = aid_pkg::OP_LDMU;
         else            k = aid_pkg::OP_UNSUP;
      end else begin
         case (op[4:3])
            2'd0:    k = ld ? aid_pkg::OP_LDMDA : aid_pkg::OP_STMDA;
            2'd1: begin
               if (!ld)                        k = aid_pkg::OP_STMIA;
               else if (op == 6'h0B && is_sp)  k = aid_pkg::OP_POPM;
               else                            k = aid_pkg::OP_LDMIA;
            end
            2'd2: begin
               if (ld)                         k = aid_pkg::OP_LDMDB;
               else if (op == 6'h12 && is_sp)  k = aid_pkg::OP_PUSHM;
               else                            k = aid_pkg::OP_STMDB;
            end
            default: k = ld ? aid_pkg::OP_LDMIB : aid_pkg::OP_STMIB;
         endcase
      end
      return k;
   endfunction

   logic                pass;
   aid_pkg::opcode_type space_class;

   // Select the decode table from bits 27:25
   always_comb begin
      case (word[27:25])
         3'd0, 3'd1: space_class = data_space(word);
         3'd2:       space_class = ls_space(word);
         3'd3:       space_class = word[4] ? aid_pkg::OP_UNSUP : ls_space(word);
         3'd4, 3'd5: space_class = br_space(word);
         default:    space_class = aid_pkg::OP_UNSUP;
      endcase
   end

   // Apply the condition field ahead of the table result
   assign pass = cond_holds(word[31:28], nzcv);

   always_comb begin
      result.condition_passed = pass;
      if (word[31:28] == aid_pkg::COND_NEVER) begin
         result.opcode_class = aid_pkg::OP_UNSUP;
      end else if (!pass) begin
         result.opcode_class = aid_pkg::OP_NOTEXEC;
      end else begin
         result.opcode_class = space_class;
      end
   end

endmodule

// ----- rtl/core/arm_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// arm_instruction_decoder
// Classifies A32 instruction words against the NZCV flags. A word is
// registered on entry, decoded by a single pass of table logic and
// registered again on exit, where its result is shown; a new word may be
// accepted every cycle while the result side does not stall.
// The output register and the input register each hold one word; a stall
// on the result side holds both, and req_stall rises only when both are
// full. Condition 1111 reports unsupported with condition_passed set; a
// failed condition reports not-executed.
// ----------------------------------------------------------------------------
module arm_instruction_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_instruction_word,
   input  logic [3:0]          req_nzcv,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output aid_pkg::opcode_type rsp_opcode_class,
   output logic                rsp_condition_passed
);

   logic                in_valid_ff, in_valid_in;
   logic [31:0]         in_word_ff;
   logic [3:0]          in_nzcv_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   aid_pkg::decode_type rsp_result_ff;
   aid_pkg::decode_type decoded;
   logic                out_advance;
   logic                in_advance;

   // Stage moves when its slot is empty or its word goes onward
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;

   aid_classify u_classify (
      .word   (in_word_ff),
      .nzcv   (in_nzcv_ff),
      .result (decoded)
   );

   // Next valid bits
   always_comb begin
      in_valid_in  = in_advance ? req_valid : in_valid_ff;
      rsp_valid_in = out_advance ? in_valid_ff : rsp_valid_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming word; hold it while the output stage is blocked
   always_ff @(posedge clock) begin
      if (in_advance && req_valid) begin
         in_word_ff <= req_instruction_word;
         in_nzcv_ff <= req_nzcv;
      end
   end

   // Register the decode result
   always_ff @(posedge clock) begin
      if (out_advance && in_valid_ff) begin
         rsp_result_ff <= decoded;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_opcode_class     = rsp_result_ff.opcode_class;
   assign rsp_condition_passed = rsp_result_ff.condition_passed;

endmodule

// ----- rtl/core/aid_checker.sv -----
// ----------------------------------------------------------------------------
// aid_checker
// Port-level checks on the A32 instruction decoder, bound to the top level.
// ----------------------------------------------------------------------------
module aid_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input aid_pkg::opcode_type rsp_opcode_class,
   input logic                rsp_condition_passed
);

   // Result word holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_opcode_class)
                                 && $stable(rsp_condition_passed))
      else $error("stalled result word changed");

   // Not-executed exactly when the condition failed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_condition_passed == (rsp_opcode_class != aid_pkg::OP_NOTEXEC)))
      else $error("condition outcome disagrees with class");

   // Class number within the defined range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_opcode_class <= aid_pkg::OP_LAST))
      else $error("class number out of range");

   // Nothing shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input side stalls only while the result side is itself stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

endmodule

bind arm_instruction_decoder aid_checker u_aid_checker (.*);

// ----- sim/arm_instruction_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// arm_instruction_decoder_tb
// Drives A32 words and flag sets into the decoder, predicts the class and the
// condition outcome of every accepted word, and checks each result in order.
// Directed words cover the special encodings; random words are shaped per
// decode table, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module arm_instruction_decoder_tb;

   // Top-level decode spaces, instruction bits 27:25
   typedef enum logic [2:0] {
      SP_DP_REG, SP_DP_IMM, SP_LS_IMM, SP_LS_REG,
      SP_BLOCK, SP_BRANCH, SP_COPROC, SP_SVC
   } space_type;

   // Data-processing operations, bits 24:21
   typedef enum logic [3:0] {
      DP_AND, DP_EOR, DP_SUB, DP_RSB, DP_ADD, DP_ADC, DP_SBC, DP_RSC,
      DP_TST, DP_TEQ, DP_CMP, DP_CMN, DP_ORR, DP_MOV, DP_BIC, DP_MVN
   } dp_op_type;

   // Shift types, bits 6:5
   typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_type;

   // Condition pairs, bits 31:29; bit 28 inverts
   typedef enum logic [2:0] {
      CC_EQ, CC_CS, CC_MI, CC_VS, CC_HI, CC_GE, CC_GT, CC_AL
   } cond_pair_type;

   localparam logic [3:0] COND_ALWAYS = 4'b1110;

   // Miscellaneous table codes
   localparam logic [2:0] MISC_BX_CLZ = 3'd1;
   localparam logic [2:0] MISC_BLX    = 3'd3;
   localparam logic [2:0] MISC_SAT    = 3'd5;
   localparam logic [1:0] MISC_OP_BX  = 2'd1;
   localparam logic [1:0] MISC_OP_CLZ = 2'd3;

   // Extra load/store forms, bits 6:5
   localparam logic [1:0] XLS_HALF    = 2'd1;
   localparam logic [1:0] XLS_SBYTE   = 2'd2;
   localparam logic [1:0] XLS_SHALF   = 2'd3;

   // Block transfer forms that become PUSH/POP with SP as base
   localparam logic [5:0] BT_POP      = 6'h0B;
   localparam logic [5:0] BT_PUSH     = 6'h12;

   localparam int unsigned RANDOM_PER_PHASE = 350;
   localparam int unsigned SETTLE_CYCLES    = 10;
   localparam int unsigned MAX_REPORTS      = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each accepted word and matches results in order
   // -------------------------------------------------------------------------
   class decode_scoreboard;
      aid_pkg::decode_type expected_q[$];
      int unsigned         mismatches;
      int unsigned         words_noted;
      int unsigned         results_checked;
      bit                  class_seen[128];

      function bit cond_holds(logic [3:0] c, logic [3:0] f);
         bit n  = f[3];
         bit z  = f[2];
         bit cy = f[1];
         bit v  = f[0];
         bit r;
         case (c[3:1])
            CC_EQ:   r = z;
            CC_CS:   r = cy;
            CC_MI:   r = n;
            CC_VS:   r = v;
            CC_HI:   r = cy && !z;
            CC_GE:   r = (n == v);
            CC_GT:   r = (n == v) && !z;
            default: r = 1'b1;
         endcase
         if (c[0] && c != aid_pkg::COND_NEVER) r = !r;
         return r;
      endfunction

      // Compare group: only the flag-setting forms exist
      function aid_pkg::opcode_type compare_class(logic [31:0] w,
                                                  aid_pkg::opcode_type base);
         if (!w[20]) return aid_pkg::OP_INVALID;
         return base + aid_pkg::opcode_type'(w[22:21]);
      endfunction

      function aid_pkg::opcode_type dp_reg_class(logic [31:0] w);
         logic [3:0] g;
         logic       no_shift;
         g = w[24:21];
         no_shift = (w[11:7] == 5'd0);
         if (g < DP_TST) return aid_pkg::OP_AND_R + aid_pkg::opcode_type'(g);
         if (g < DP_ORR) return compare_class(w, aid_pkg::OP_TST_R);
         case (g)
            DP_ORR: return aid_pkg::OP_ORR_R;
            DP_MOV: begin
               case (w[6:5])
                  SH_LSL:  return no_shift ? aid_pkg::OP_MOV_R : aid_pkg::OP_LSL_I;
                  SH_LSR:  return aid_pkg::OP_LSR_I;
                  SH_ASR:  return aid_pkg::OP_ASR_I;
                  default: return no_shift ? aid_pkg::OP_RRX_R : aid_pkg::OP_ROR_I;
               endcase
            end
            DP_BIC:  return aid_pkg::OP_BIC_R;
            default: return aid_pkg::OP_MVN_R;
         endcase
      endfunction

      function aid_pkg::opcode_type dp_rsreg_class(logic [31:0] w);
         logic [3:0] g;
         g = w[24:21];
         if (g < DP_TST) return aid_pkg::OP_AND_S + aid_pkg::opcode_type'(g);
         if (g < DP_ORR) return compare_class(w, aid_pkg::OP_TST_S);
         case (g)
            DP_ORR:  return aid_pkg::OP_ORR_S;
            DP_MOV:  return aid_pkg::OP_LSL_S + aid_pkg::opcode_type'(w[6:5]);
            DP_BIC:  return aid_pkg::OP_BIC_S;
            default: return aid_pkg::OP_MVN_S;
         endcase
      endfunction

      function aid_pkg::opcode_type dp_imm_class(logic [31:0] w);
         logic [3:0] g;
         g = w[24:21];
         // ADD/SUB with PC as base form an address
         if ((g == DP_SUB || g == DP_ADD) && w[19:16] == aid_pkg::RN_PC)
            return aid_pkg::OP_ADR_I;
         if (g < DP_RSB) return aid_pkg::OP_AND_I + aid_pkg::opcode_type'(g);
         if (g < DP_TST)
            return aid_pkg::OP_ADR_I + 7'd1 + aid_pkg::opcode_type'(g - DP_RSB);
         if (g < DP_ORR) return compare_class(w, aid_pkg::OP_TST_I);
         case (g)
            DP_ORR:  return aid_pkg::OP_ORR_I;
            DP_MOV:  return aid_pkg::OP_MOVW;
            DP_BIC:  return aid_pkg::OP_BIC_I;
            default: return aid_pkg::OP_MVN_I;
         endcase
      endfunction

      function aid_pkg::opcode_type misc_class(logic [31:0] w);
         logic [1:0] op;
         logic [2:0] op2;
         op  = w[22:21];
         op2 = w[6:4];
         if (op2 == MISC_BX_CLZ) begin
            if (op == MISC_OP_BX) return aid_pkg::OP_BXR;
            if (op == MISC_OP_CLZ) return aid_pkg::OP_CLZR;
            return aid_pkg::OP_INVALID;
         end
         if (op2 == MISC_BLX && op == MISC_OP_BX) return aid_pkg::OP_BLXR;
         if (op2 == MISC_SAT) return aid_pkg::OP_QADDR + aid_pkg::opcode_type'(op);
         return aid_pkg::OP_UNSUP;
      endfunction

      function aid_pkg::opcode_type extra_ls_class(logic [31:0] w);
         logic imm, ld, lit;
         imm = w[22];
         ld  = w[20];
         lit = (w[19:16] == aid_pkg::RN_PC);
         case (w[6:5])
            XLS_HALF: begin
               if (!imm) return ld ? aid_pkg::OP_LDRH_R : aid_pkg::OP_STRH_R;
               if (ld) return lit ? aid_pkg::OP_LDRH_L : aid_pkg::OP_LDRH_I;
               return aid_pkg::OP_STRH_I;
            end
            XLS_SBYTE: begin
               if (!imm) return ld ? aid_pkg::OP_LDRSB_R : aid_pkg::OP_LDRD_R;
               if (ld) return lit ? aid_pkg::OP_LDRSB_L : aid_pkg::OP_LDRSB_I;
               return lit ? aid_pkg::OP_LDRD_L : aid_pkg::OP_LDRD_I;
            end
            XLS_SHALF: begin
               if (!imm) return ld ? aid_pkg::OP_LDRSH_R : aid_pkg::OP_STRD_R;
               if (ld) return lit ? aid_pkg::OP_LDRSH_L : aid_pkg::OP_LDRSH_I;
               return aid_pkg::OP_STRD_I;
            end
            default: return aid_pkg::OP_INVALID;
         endcase
      endfunction

      // Unprivileged extra load/store: doubleword loads and stores have no user form
      function aid_pkg::opcode_type extra_ls_user_class(logic [31:0] w);
         logic ld;
         ld = w[20];
         case (w[6:5])
            XLS_HALF:  return ld ? aid_pkg::OP_LDRHT : aid_pkg::OP_STRHT;
            XLS_SBYTE: return ld ? aid_pkg::OP_LDRSBT : aid_pkg::OP_INVALID;
            XLS_SHALF: return ld ? aid_pkg::OP_LDRSHT : aid_pkg::OP_INVALID;
            default:   return aid_pkg::OP_INVALID;
         endcase
      endfunction

      function aid_pkg::opcode_type data_space_class(logic [31:0] w);
         logic [4:0] op1;
         logic [3:0] op2;
         logic       grp;
         op1 = w[24:20];
         op2 = w[7:4];
         grp = ((op1 & 5'b11001) == 5'b10000);
         if (w[25]) begin
            if (!grp) return dp_imm_class(w);
            if (op1 == 5'b10000) return aid_pkg::OP_MOVW;
            if (op1 == 5'b10100) return aid_pkg::OP_MOVT;
            return aid_pkg::OP_UNSUP;
         end
         if (!grp) begin
            if (!op2[0]) return dp_reg_class(w);
            if (!op2[3]) return dp_rsreg_class(w);
         end else begin
            if (!op2[3]) return misc_class(w);
            if (!op2[0]) return aid_pkg::OP_UNSUP;
         end
         // Multiply and synchronisation sit at op2 1001
         if (op2 == 4'b1001) return aid_pkg::OP_UNSUP;
         if (op2 == 4'b1011 || (op2 & 4'b1101) == 4'b1101) begin
            if ((op1 & 5'b10010) == 5'b00010) return extra_ls_user_class(w);
            return extra_ls_class(w);
         end
         return aid_pkg::OP_INVALID;
      endfunction

      function aid_pkg::opcode_type ls_space_class(logic [31:0] w);
         logic byt, ld, lit;
         byt = w[22];
         ld  = w[20];
         lit = (w[19:16] == aid_pkg::RN_PC);
         if ((w[24:20] & 5'b10010) == 5'b00010) begin
            if (byt) return ld ? aid_pkg::OP_LDRBT : aid_pkg::OP_STRBT;
            return ld ? aid_pkg::OP_LDRT : aid_pkg::OP_STRT;
         end
         if (w[25]) begin
            if (byt) return ld ? aid_pkg::OP_LDRB_R : aid_pkg::OP_STRB_R;
            return ld ? aid_pkg::OP_LDR_R : aid_pkg::OP_STR_R;
         end
         if (byt) begin
            if (ld) return lit ? aid_pkg::OP_LDRB_L : aid_pkg::OP_LDRB_I;
            return aid_pkg::OP_STRB_I;
         end
         if (ld) return lit ? aid_pkg::OP_LDR_L : aid_pkg::OP_LDR_I;
         return aid_pkg::OP_STR_I;
      endfunction

      function aid_pkg::opcode_type block_space_class(logic [31:0] w);
         logic [5:0] op;
         logic       ld, sp_base;
         op      = w[25:20];
         ld      = op[0];
         sp_base = (w[19:16] == aid_pkg::RN_SP);
         if (op[5]) return op[4] ? aid_pkg::OP_BLI : aid_pkg::OP_BR;
         // User-register form; with PC in the list it is an exception return
         if (op[2]) begin
            if (!ld) return aid_pkg::OP_STMU;
            return w[15] ? aid_pkg::OP_UNSUP : aid_pkg::OP_LDMU;
         end
         case (op[4:3])
            2'd0:    return ld ? aid_pkg::OP_LDMDA : aid_pkg::OP_STMDA;
            2'd1: begin
               if (!ld) return aid_pkg::OP_STMIA;
               return (op == BT_POP && sp_base) ? aid_pkg::OP_POPM : aid_pkg::OP_LDMIA;
            end
            2'd2: begin
               if (ld) return aid_pkg::OP_LDMDB;
               return (op == BT_PUSH && sp_base) ? aid_pkg::OP_PUSHM : aid_pkg::OP_STMDB;
            end
            default: return ld ? aid_pkg::OP_LDMIB : aid_pkg::OP_STMIB;
         endcase
      endfunction

      function aid_pkg::decode_type classify(logic [31:0] w, logic [3:0] f);
         aid_pkg::decode_type d;
         d.condition_passed = cond_holds(w[31:28], f);
         if (w[31:28] == aid_pkg::COND_NEVER)
            d.opcode_class = aid_pkg::OP_UNSUP;
         else if (!d.condition_passed)
            d.opcode_class = aid_pkg::OP_NOTEXEC;
         else begin
            case (w[27:25])
               SP_DP_REG, SP_DP_IMM: d.opcode_class = data_space_class(w);
               SP_LS_IMM:            d.opcode_class = ls_space_class(w);
               SP_LS_REG:  d.opcode_class = w[4] ? aid_pkg::OP_UNSUP : ls_space_class(w);
               SP_BLOCK, SP_BRANCH:  d.opcode_class = block_space_class(w);
               default:              d.opcode_class = aid_pkg::OP_UNSUP;
            endcase
         end
         return d;
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s, expected %0d, got %0d", what, want, got);
      endfunction

      function void note_word(logic [31:0] w, logic [3:0] f);
         expected_q.push_back(classify(w, f));
         words_noted++;
      endfunction

      function void check_result(aid_pkg::opcode_type oc, logic cp);
         aid_pkg::decode_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            report("result with no word pending, class", 0, 32'(oc));
            return;
         end
         want = expected_q.pop_front();
         class_seen[want.opcode_class] = 1'b1;
         if (oc !== want.opcode_class)
            report("opcode_class", 32'(want.opcode_class), 32'(oc));
         if (cp !== want.condition_passed)
            report("condition_passed", 32'(want.condition_passed), 32'(cp));
      endfunction

      function void flush_leftover();
         if (expected_q.size() != 0)
            report("words still waiting for a result", 0, expected_q.size());
      endfunction

      function int unsigned classes_covered();
         int unsigned n;
         n = 0;
         foreach (class_seen[i]) if (class_seen[i]) n++;
         return n;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [31:0]         req_instruction_word = 32'd0;
   logic [3:0]          req_nzcv = 4'd0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   aid_pkg::opcode_type rsp_opcode_class;
   logic                rsp_condition_passed;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   decode_scoreboard decode_sb = new;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   arm_instruction_decoder dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instruction_word (req_instruction_word),
      .req_nzcv             (req_nzcv),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_opcode_class     (rsp_opcode_class),
      .rsp_condition_passed (rsp_condition_passed)
   );

   // Stall the result side at random, changing on the falling edge
   always @(negedge clock) begin
      if (!reset)
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // Sample both handshakes on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            decode_sb.note_word(req_instruction_word, req_nzcv);
         if (rsp_valid === 1'b1 && !rsp_stall)
            decode_sb.check_result(rsp_opcode_class, rsp_condition_passed);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks; all called and returning on a falling edge
   // -------------------------------------------------------------------------
   task automatic send_word(input logic [31:0] w, input logic [3:0] f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid            = 1'b1;
      req_instruction_word = w;
      req_nzcv             = f;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Hold off the sender until every pending word has its result
   task automatic wait_drained();
      req_valid = 1'b0;
      while (decode_sb.expected_q.size() != 0) @(negedge clock);
   endtask

   // Build one word aimed at a chosen decode table, with some pure noise
   task automatic send_shaped_word();
      logic [31:0] w;
      logic [3:0]  f;
      w = $urandom;
      f = 4'($urandom_range(15));
      if ($urandom_range(99) < 60) w[31:28] = COND_ALWAYS;
      case ($urandom_range(9))
         0: ;
         1: begin
            w[27:25] = SP_DP_REG;
            w[4]     = 1'b0;
         end
         2: begin
            w[27:25] = SP_DP_REG;
            w[7]     = 1'b0;
            w[4]     = 1'b1;
         end
         3: begin
            // miscellaneous group: op1 10xx0 with op2 0xxx
            w[27:25] = SP_DP_REG;
            w[24:23] = 2'b10;
            w[20]    = 1'b0;
            w[7]     = 1'b0;
         end
         4: begin
            w[27:25] = SP_DP_REG;
            w[7]     = 1'b1;
            w[4]     = 1'b1;
         end
         5: w[27:25] = SP_DP_IMM;
         6, 7: w[27:26] = 2'b01;
         8: begin
            w[27:26] = 2'b10;
            if ($urandom_range(3) == 0) begin
               w[25:20] = $urandom_range(1) ? BT_POP : BT_PUSH;
               w[19:16] = aid_pkg::RN_SP;
            end
         end
         default: w[27:26] = 2'b11;
      endcase
      if ($urandom_range(3) == 0)
         w[19:16] = $urandom_range(1) ? aid_pkg::RN_PC : aid_pkg::RN_SP;
      send_word(w, f);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RANDOM_PER_PHASE) send_shaped_word();
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct  = 37;
      recv_stall_pct = 61;

      // Condition handling: failed, passed, never
      send_word(32'h0000_0000, 4'b0000);  // EQ with Z clear: not executed
      send_word(32'h0000_0000, 4'b0100);  // EQ with Z set: AND register
      send_word(32'hFFFF_FFFF, 4'b1111);  // unconditional space
      send_word(32'hCFFF_FFFF, 4'b1001);  // GT with N == V and Z clear
      // Data processing and miscellaneous
      send_word(32'hE1A0_0000, 4'b0000);  // MOV register
      send_word(32'hE1A0_0060, 4'b0000);  // RRX
      send_word(32'hE000_0090, 4'b0000);  // multiply: unsupported
      send_word(32'hE12F_FF1E, 4'b0000);  // BX
      send_word(32'hE16F_0F10, 4'b0000);  // CLZ
      send_word(32'hE12F_FF33, 4'b0000);  // BLX register
      send_word(32'hE100_0050, 4'b0000);  // QADD
      send_word(32'hE100_0010, 4'b0000);  // misc hole: invalid
      send_word(32'hE300_0000, 4'b0000);  // MOVW
      send_word(32'hE340_0000, 4'b0000);  // MOVT
      send_word(32'hE28F_0000, 4'b0000);  // ADD immediate from PC: ADR
      // Extra load/store, normal and unprivileged
      send_word(32'hE14F_00D0, 4'b0000);  // LDRD literal
      send_word(32'hE0E0_00D0, 4'b0000);  // user doubleword load: invalid
      send_word(32'hE0F0_00D0, 4'b0000);  // LDRSBT
      send_word(32'hE07F_00B0, 4'b0000);  // LDRHT
      // Load/store, block transfer, branch, coprocessor
      send_word(32'hE59F_0000, 4'b0000);  // LDR literal
      send_word(32'hE610_0010, 4'b0000);  // register form with bit 4: media
      send_word(32'hE8BD_8000, 4'b0000);  // POP
      send_word(32'hE92D_4000, 4'b0000);  // PUSH
      send_word(32'hE8D0_8000, 4'b0000);  // LDM user form with PC: exception return
      send_word(32'hE8D0_0001, 4'b0000);  // LDM user registers
      send_word(32'hEB00_0000, 4'b0000);  // BL
      send_word(32'hEE00_0000, 4'b0000);  // coprocessor

      run_phase(37, 61);
      run_phase(61, 37);
      run_phase(0, 0);

      // Let any stray result surface before closing
      repeat (SETTLE_CYCLES) @(negedge clock);
      decode_sb.flush_leftover();

      $display("summary: %0d words sent, %0d results checked, %0d classes seen, %0d mismatches",
               decode_sb.words_noted, decode_sb.results_checked,
               decode_sb.classes_covered(), decode_sb.mismatches);
      if (decode_sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- arm_instruction_decoder.f -----
rtl/core/aid_pkg.sv
rtl/core/aid_classify.sv
rtl/core/arm_instruction_decoder.sv
rtl/core/aid_checker.sv
sim/arm_instruction_decoder_tb.sv
